// ===== src/tomasulo_issue_execute_writeback_defines.svh =====
// Assertion macros for the reservation station engine.
`ifndef TOMASULO_ISSUE_EXECUTE_WRITEBACK_DEFINES_SVH
`define TOMASULO_ISSUE_EXECUTE_WRITEBACK_DEFINES_SVH
`ifndef SYNTHESIS
`define TIEW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TIEW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TIEW_ASSERT(label, clk, rstn, prop, msg)
`define TIEW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/tiew_pkg.sv =====
// ---------------------------------------------------------------------------
// tiew_pkg
// Types and constants shared by the reservation station engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tiew_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] CFG_ADD_LAT = 2'd0;
    localparam logic [1:0] CFG_MUL_LAT = 2'd1;
    localparam logic [1:0] CFG_DIV_LAT = 2'd2;

    localparam logic [5:0] ADD_LAT_RST = 6'd4;
    localparam logic [5:0] MUL_LAT_RST = 6'd12;
    localparam logic [5:0] DIV_LAT_RST = 6'd38;

    typedef struct packed {
        logic       issue_valid;
        logic [1:0] opcode;
        logic [3:0] dest_reg;
        logic [3:0] src_a_reg;
        logic [3:0] src_b_reg;
    } tiew_in_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  wb_reg;
        logic signed [31:0] wb_value;
        logic [2:0]  wb_station;
        logic        issue_accepted;
        logic [2:0]  issue_station;
        logic        last;
    } tiew_out_t;

    // Request / response between sequencer and the shared ALU.
    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } tiew_alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } tiew_alu_rsp_t;

endpackage

// ===== src/tiew_alu.sv =====
// ---------------------------------------------------------------------------
// tiew_alu
// Shared arithmetic unit: add/sub/mul, signed divide
// one quotient bit per cycle (restoring).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tomasulo_issue_execute_writeback_defines.svh"

module tiew_alu
    import tiew_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  tiew_alu_req_t req,
    output tiew_alu_rsp_t rsp
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_DONE = 4'b1000
    } alu_state_t;

    alu_state_t  state_reg, state_next;
    logic [31:0] a_reg, b_reg, res_reg;
    logic [31:0] rem_reg, quo_reg;
    logic [4:0]  bit_reg;
    logic        neg_reg;
    logic [1:0]  op_reg;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, b_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    if (req.op == OP_MUL) state_next = A_MUL;
                    else if (req.op == OP_DIV && req.b != 32'd0) state_next = A_DIV;
                    else state_next = A_DONE;
                end
            end
            A_MUL:   state_next = A_DONE;
            A_DIV:   if (bit_reg == 5'd31) state_next = A_DONE;
            A_DONE:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: begin
                op_reg  <= req.op;
                a_reg   <= req.a;
                neg_reg <= req.a[31] ^ req.b[31];
                bit_reg <= 5'd0;
                rem_reg <= 32'd0;
                quo_reg <= req.a[31] ? (32'd0 - req.a) : req.a;
                b_reg   <= (req.op == OP_DIV && req.b[31]) ? (32'd0 - req.b) : req.b;
                case (req.op)
                    OP_ADD:  res_reg <= req.a + req.b;
                    OP_SUB:  res_reg <= req.a - req.b;
                    default: res_reg <= 32'hFFFF_FFFF;
                endcase
            end
            A_MUL: res_reg <= a_reg * b_reg;
            A_DIV: begin
                bit_reg <= bit_reg + 5'd1;
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                if (bit_reg == 5'd31) begin
                    if (!trial[32])
                        res_reg <= neg_reg ? (32'd0 - {quo_reg[30:0], 1'b1})
                                           : {quo_reg[30:0], 1'b1};
                    else
                        res_reg <= neg_reg ? (32'd0 - {quo_reg[30:0], 1'b0})
                                           : {quo_reg[30:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign rsp.done   = (state_reg == A_DONE);
    assign rsp.result = res_reg;

    `TIEW_ASSERT(a_div_op, aclk, aresetn, (state_reg == A_DIV) |-> (op_reg == OP_DIV), "divide state with non divide op")
    `TIEW_ASSERT(a_done_one, aclk, aresetn, (state_reg == A_DONE) |=> (state_reg == A_IDLE), "done held")
    `TIEW_ASSERT(a_mul_len, aclk, aresetn, (state_reg == A_MUL) |=> (state_reg == A_DONE), "multiply took too long")

endmodule

// ===== src/tomasulo_issue_execute_writeback.sv =====
// ---------------------------------------------------------------------------
// tomasulo_issue_execute_writeback
// Reservation station engine: one input word is one tick (issue, execute,
// writeback); results are writeback words then a summary word.
// ---------------------------------------------------------------------------
//  channel  | ports            | carries
//  input    | s_valid/s_ready  | tiew_in_t, one tick
//  result   | m_valid/m_ready  | tiew_out_t, writebacks then summary
//  config   | cfg_valid/ready  | latency register index and value
//
// A tick runs through accept, execute sweep, writeback sweep, summary and
// summary handoff, plus ALU time for each station that finishes (least for
// add/sub or divide by zero, more for multiply, most for divide) plus the
// handoff of each writeback word, more if m_ready stalls. The shared ALU and
// the station-by-station sweeps set the tick length. Reset is synchronous and
// clears all state but out_reg; s_ready is low while a tick is in progress.
`timescale 1ns / 1ps
`include "tomasulo_issue_execute_writeback_defines.svh"

module tomasulo_issue_execute_writeback
    import tiew_pkg::*;
#(
    parameter int STATIONS = 8,
    parameter int REGS     = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tiew_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output tiew_out_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    localparam int SW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int RW = (REGS > 1) ? $clog2(REGS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_ALU   = 6'b000100,
        S_WB    = 6'b001000,
        S_EMIT  = 6'b010000,
        S_SUMM  = 6'b100000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [5:0] add_lat_reg, mul_lat_reg, div_lat_reg;

    logic [31:0]   reg_value_reg   [REGS];
    logic [REGS-1:0] reg_pending_reg;
    logic [SW-1:0] reg_producer_reg [REGS];

    logic [STATIONS-1:0] busy_reg, wa_valid_reg, wb_valid_reg, rdy_reg, dly_reg;
    logic [1:0]    op_reg    [STATIONS];
    logic [RW-1:0] dest_reg  [STATIONS];
    logic [SW-1:0] wa_tag_reg [STATIONS];
    logic [SW-1:0] wb_tag_reg [STATIONS];
    logic [31:0]   opa_reg   [STATIONS];
    logic [31:0]   opb_reg   [STATIONS];
    logic [5:0]    cnt_reg   [STATIONS];
    logic [31:0]   res_reg   [STATIONS];

    logic [SW:0]   idx_reg;
    logic [SW-1:0] st;
    logic          acc_reg;
    logic [SW-1:0] ist_reg;
    tiew_out_t     out_reg;
    logic          out_valid_reg;
    logic          out_load;

    tiew_alu_req_t alu_req;
    tiew_alu_rsp_t alu_rsp;

    assign st = idx_reg[SW-1:0];

    // Lowest free station
    logic          free_found;
    logic [SW-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = STATIONS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // Execute check for the current station
    logic [5:0] lat, cnt_inc, lat_eff;
    logic       exec_go, exec_fin;
    always_comb begin
        case (op_reg[st])
            OP_ADD, OP_SUB: lat = add_lat_reg;
            OP_MUL:         lat = mul_lat_reg;
            default:        lat = div_lat_reg;
        endcase
        lat_eff  = lat;
        cnt_inc  = cnt_reg[st] + 6'd1;
        exec_go  = busy_reg[st] && !wa_valid_reg[st] && !wb_valid_reg[st] && !rdy_reg[st];
        exec_fin = exec_go && (cnt_inc >= lat_eff);
    end

    logic last_st;
    assign last_st = (idx_reg == (SW+1)'(STATIONS - 1));

    assign s_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // Output word load: writeback or summary, when the slot is free
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_SUMM)) &&
                      (!out_valid_reg || m_ready);

    assign alu_req.start = (state_reg == S_EXEC) && exec_fin;
    assign alu_req.op    = op_reg[st];
    assign alu_req.a     = opa_reg[st];
    assign alu_req.b     = opb_reg[st];

    tiew_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_EXEC;
            S_EXEC: begin
                if (exec_fin) state_next = S_ALU;
                else if (last_st) state_next = S_WB;
            end
            S_ALU: begin
                if (alu_rsp.done) state_next = last_st ? S_WB : S_EXEC;
            end
            S_WB: begin
                if (rdy_reg[st] && dly_reg[st]) state_next = S_EMIT;
                else if (last_st) state_next = S_SUMM;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) state_next = last_st ? S_SUMM : S_WB;
            end
            S_SUMM: if (!out_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            add_lat_reg     <= ADD_LAT_RST;
            mul_lat_reg     <= MUL_LAT_RST;
            div_lat_reg     <= DIV_LAT_RST;
            reg_pending_reg <= '0;
            busy_reg        <= '0;
            wa_valid_reg    <= '0;
            wb_valid_reg    <= '0;
            rdy_reg         <= '0;
            dly_reg         <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            acc_reg         <= 1'b0;
            ist_reg         <= '0;
            for (int r = 0; r < REGS; r++) begin
                reg_value_reg[r]    <= '0;
                reg_producer_reg[r] <= '0;
            end
            for (int i = 0; i < STATIONS; i++) begin
                op_reg[i]     <= '0;
                dest_reg[i]   <= '0;
                wa_tag_reg[i] <= '0;
                wb_tag_reg[i] <= '0;
                opa_reg[i]    <= '0;
                opb_reg[i]    <= '0;
                cnt_reg[i]    <= '0;
                res_reg[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (cfg_valid && cfg_ready) begin
                        case (cfg_index)
                            CFG_ADD_LAT: add_lat_reg <= cfg_data;
                            CFG_MUL_LAT: mul_lat_reg <= cfg_data;
                            CFG_DIV_LAT: div_lat_reg <= cfg_data;
                            default: ;
                        endcase
                    end
                    idx_reg <= '0;
                    if (s_valid && s_ready) begin
                        acc_reg <= 1'b0;
                        ist_reg <= '0;
                        // Issue
                        if (s_data.issue_valid && free_found) begin
                            logic [RW-1:0] d, ra, rb;
                            d  = RW'(s_data.dest_reg % REGS);
                            ra = RW'(s_data.src_a_reg % REGS);
                            rb = RW'(s_data.src_b_reg % REGS);
                            acc_reg <= 1'b1;
                            ist_reg <= free_idx;
                            busy_reg[free_idx] <= 1'b1;
                            op_reg[free_idx]   <= s_data.opcode;
                            dest_reg[free_idx] <= d;
                            wa_valid_reg[free_idx] <= reg_pending_reg[ra];
                            wa_tag_reg[free_idx]   <= reg_producer_reg[ra];
                            if (!reg_pending_reg[ra]) opa_reg[free_idx] <= reg_value_reg[ra];
                            wb_valid_reg[free_idx] <= reg_pending_reg[rb];
                            wb_tag_reg[free_idx]   <= reg_producer_reg[rb];
                            if (!reg_pending_reg[rb]) opb_reg[free_idx] <= reg_value_reg[rb];
                            cnt_reg[free_idx] <= '0;
                            rdy_reg[free_idx] <= 1'b0;
                            dly_reg[free_idx] <= 1'b0;
                            reg_pending_reg[d]  <= 1'b1;
                            reg_producer_reg[d] <= free_idx;
                        end
                    end
                end
                S_EXEC: begin
                    if (exec_go) cnt_reg[st] <= exec_fin ? 6'd0 : cnt_inc;
                    if (!exec_fin) idx_reg <= last_st ? '0 : idx_reg + 1'b1;
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        res_reg[st] <= alu_rsp.result;
                        rdy_reg[st] <= 1'b1;
                        idx_reg     <= last_st ? '0 : idx_reg + 1'b1;
                    end
                end
                S_WB: begin
                    if (rdy_reg[st] && !dly_reg[st]) dly_reg[st] <= 1'b1;
                    if (!(rdy_reg[st] && dly_reg[st])) begin
                        if (!last_st) idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        reg_value_reg[dest_reg[st]] <= res_reg[st];
                        if (reg_pending_reg[dest_reg[st]] &&
                            reg_producer_reg[dest_reg[st]] == st)
                            reg_pending_reg[dest_reg[st]] <= 1'b0;
                        for (int t = 0; t < STATIONS; t++) begin
                            if (busy_reg[t] && wa_valid_reg[t] && wa_tag_reg[t] == st) begin
                                opa_reg[t]      <= res_reg[st];
                                wa_valid_reg[t] <= 1'b0;
                            end
                            if (busy_reg[t] && wb_valid_reg[t] && wb_tag_reg[t] == st) begin
                                opb_reg[t]      <= res_reg[st];
                                wb_valid_reg[t] <= 1'b0;
                            end
                        end
                        busy_reg[st] <= 1'b0;
                        rdy_reg[st]  <= 1'b0;
                        dly_reg[st]  <= 1'b0;
                        out_reg.kind           <= 1'b0;
                        out_reg.wb_reg         <= 4'(dest_reg[st]);
                        out_reg.wb_value       <= res_reg[st];
                        out_reg.wb_station     <= 3'(st);
                        out_reg.issue_accepted <= 1'b0;
                        out_reg.issue_station  <= 3'd0;
                        out_reg.last           <= 1'b0;
                        if (!last_st) idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SUMM: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg.kind           <= 1'b1;
                        out_reg.wb_reg         <= 4'd0;
                        out_reg.wb_value       <= 32'sd0;
                        out_reg.wb_station     <= 3'd0;
                        out_reg.issue_accepted <= acc_reg;
                        out_reg.issue_station  <= 3'(ist_reg);
                        out_reg.last           <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    `TIEW_ASSERT(a_no_input_busy, aclk, aresetn, (state_reg != S_IDLE) |-> !s_ready, "input taken mid tick")
    `TIEW_ASSERT(a_emit_free, aclk, aresetn, (state_reg == S_EMIT && (!out_valid_reg || m_ready)) |=> !busy_reg[$past(st)], "writeback did not free station")
    `TIEW_ASSERT(a_summ_last, aclk, aresetn, ($past(state_reg) == S_SUMM && state_reg == S_IDLE) |-> (out_valid_reg && out_reg.last), "summary missing")
    `TIEW_ASSERT(a_rdy_busy, aclk, aresetn, ((rdy_reg & ~busy_reg) == '0), "result on idle station")

endmodule

// ===== sim/tomasulo_issue_execute_writeback_tb.sv =====
// ---------------------------------------------------------------------------
// tomasulo_issue_execute_writeback_tb
// Self-checking bench for the reservation station engine. Every input word
// is one tick. A cycle-free model of the stations and the register file
// predicts the writeback words and the summary word of each tick. The
// monitor checks every result word against that prediction, field by field.
// Latency settings change between phases, only while the engine is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tomasulo_issue_execute_writeback_tb;
    import tiew_pkg::*;

    localparam int NST  = 8;
    localparam int NREG = 16;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    tiew_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    tiew_out_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [5:0] cfg_data = '0;

    tomasulo_issue_execute_writeback dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    // ticks waiting to be driven, result words waiting to be seen
    tiew_in_t  tick_q[$];
    tiew_out_t wb_expect_q[$];
    int        n_ticks = 0;
    int        n_errors = 0;
    logic      quiet;
    int        hold_left = 0;
    logic      hold_done = 1'b0;

    // model latency registers
    logic [5:0] lat_add = ADD_LAT_RST, lat_mul = MUL_LAT_RST, lat_div = DIV_LAT_RST;

    // model register file and stations
    logic [31:0] rf_val[NREG];
    logic        rf_pend[NREG];
    logic [2:0]  rf_prod[NREG];
    logic        st_busy[NST];
    logic [1:0]  st_op[NST];
    logic [3:0]  st_dest[NST];
    logic [2:0]  st_tag_a[NST], st_tag_b[NST];
    logic        st_wait_a[NST], st_wait_b[NST];
    logic [31:0] st_a[NST], st_b[NST], st_res[NST];
    logic [5:0]  st_cnt[NST];
    logic        st_done[NST], st_delay[NST];

    initial begin
        for (int i = 0; i < NREG; i++) begin
            rf_val[i] = '0; rf_pend[i] = 1'b0; rf_prod[i] = '0;
        end
        for (int i = 0; i < NST; i++) begin
            st_busy[i] = 0; st_op[i] = '0; st_dest[i] = '0;
            st_tag_a[i] = '0; st_tag_b[i] = '0; st_wait_a[i] = 0; st_wait_b[i] = 0;
            st_a[i] = '0; st_b[i] = '0; st_res[i] = '0; st_cnt[i] = '0;
            st_done[i] = 0; st_delay[i] = 0;
        end
    end

    function automatic logic [31:0] alu_result(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            default: begin
                if (b == 32'd0) return 32'hFFFF_FFFF;
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                return (a[31] ^ b[31]) ? -q : q;
            end
        endcase
    endfunction

    // one tick: issue, execute, writeback; pushes the expected words
    function automatic void run_tick(tiew_in_t w);
        logic       took;
        logic [2:0] slot;
        logic [5:0] lat;
        tiew_out_t  o;
        took = 1'b0;
        slot = '0;
        if (w.issue_valid) begin
            for (int s = 0; s < NST; s++) begin
                if (!took && !st_busy[s]) begin
                    st_busy[s] = 1; st_op[s] = w.opcode; st_dest[s] = w.dest_reg;
                    if (rf_pend[w.src_a_reg]) begin
                        st_tag_a[s] = rf_prod[w.src_a_reg]; st_wait_a[s] = 1;
                    end else begin
                        st_a[s] = rf_val[w.src_a_reg]; st_wait_a[s] = 0;
                    end
                    if (rf_pend[w.src_b_reg]) begin
                        st_tag_b[s] = rf_prod[w.src_b_reg]; st_wait_b[s] = 1;
                    end else begin
                        st_b[s] = rf_val[w.src_b_reg]; st_wait_b[s] = 0;
                    end
                    st_cnt[s] = '0; st_done[s] = 0; st_delay[s] = 0;
                    rf_pend[w.dest_reg] = 1;
                    rf_prod[w.dest_reg] = 3'(s);
                    took = 1'b1;
                    slot = 3'(s);
                end
            end
        end
        // execute
        for (int s = 0; s < NST; s++) begin
            if (st_busy[s] && !st_wait_a[s] && !st_wait_b[s] && !st_done[s]) begin
                st_cnt[s] = st_cnt[s] + 6'd1;
                lat = (st_op[s] == OP_ADD || st_op[s] == OP_SUB) ? lat_add
                    : (st_op[s] == OP_MUL) ? lat_mul : lat_div;
                if (st_cnt[s] >= lat) begin
                    st_res[s] = alu_result(st_op[s], st_a[s], st_b[s]);
                    st_done[s] = 1; st_cnt[s] = '0;
                end
            end
        end
        // writeback in station order
        for (int s = 0; s < NST; s++) begin
            if (st_done[s]) begin
                if (!st_delay[s]) begin
                    st_delay[s] = 1;
                end else begin
                    rf_val[st_dest[s]] = st_res[s];
                    if (rf_pend[st_dest[s]] && rf_prod[st_dest[s]] == 3'(s))
                        rf_pend[st_dest[s]] = 0;
                    for (int t = 0; t < NST; t++) begin
                        if (st_busy[t]) begin
                            if (st_wait_a[t] && st_tag_a[t] == 3'(s)) begin
                                st_a[t] = st_res[s]; st_wait_a[t] = 0;
                            end
                            if (st_wait_b[t] && st_tag_b[t] == 3'(s)) begin
                                st_b[t] = st_res[s]; st_wait_b[t] = 0;
                            end
                        end
                    end
                    st_busy[s] = 0; st_done[s] = 0; st_delay[s] = 0;
                    o = '0;
                    o.wb_reg = st_dest[s];
                    o.wb_value = st_res[s];
                    o.wb_station = 3'(s);
                    wb_expect_q.push_back(o);
                end
            end
        end
        o = '0;
        o.kind = 1'b1;
        o.issue_accepted = took;
        o.issue_station = slot;
        o.last = 1'b1;
        wb_expect_q.push_back(o);
    endfunction

    // no idling on either side for a stretch of ticks
    assign quiet = (n_ticks >= 100) && (n_ticks < 160);

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                run_tick(s_data);
                n_ticks <= n_ticks + 1;
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (tick_q.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
                s_valid <= 1'b1;
                s_data <= tick_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once, so the engine backs up into its input
    always @(posedge aclk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && n_ticks >= 200) begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        tiew_out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (wb_expect_q.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("unexpected result word %p", m_data);
                end else begin
                    e = wb_expect_q.pop_front();
                    if (m_data !== e) begin
                        n_errors <= n_errors + 1;
                        if (n_errors < 10)
                            $display("mismatch: expected %p, got %p", e, m_data);
                    end
                end
            end
            m_ready <= (hold_left > 0) ? 1'b0 : (quiet || $urandom_range(99) >= 17);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ADD_LAT: lat_add = val;
            CFG_MUL_LAT: lat_mul = val;
            CFG_DIV_LAT: lat_div = val;
            default: ;
        endcase
    endtask

    task automatic set_latencies(logic [5:0] a, logic [5:0] m, logic [5:0] d);
        write_reg(CFG_ADD_LAT, a);
        write_reg(CFG_MUL_LAT, m);
        write_reg(CFG_DIV_LAT, d);
    endtask

    // directed instruction followed by an empty tick with random fields
    task automatic push_instr(logic [1:0] op, logic [3:0] d, logic [3:0] a, logic [3:0] b);
        tiew_in_t w;
        w = '{issue_valid: 1'b1, opcode: op, dest_reg: d, src_a_reg: a, src_b_reg: b};
        tick_q.push_back(w);
        w = tiew_in_t'($urandom);
        w.issue_valid = 1'b0;
        tick_q.push_back(w);
    endtask

    task automatic push_random(int count);
        tiew_in_t w;
        for (int i = 0; i < count; i++) begin
            w = tiew_in_t'($urandom);
            w.issue_valid = ($urandom_range(99) < 85);
            tick_q.push_back(w);
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (tick_q.size() > 0 || s_valid || wb_expect_q.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: build extreme values from zeros, short latencies
        set_latencies(6'd1, 6'd1, 6'd1);
        write_reg(2'd3, 6'd63);
        push_instr(OP_DIV, 4'd1, 4'd0, 4'd0);    // divide by zero
        push_instr(OP_SUB, 4'd2, 4'd0, 4'd1);
        push_instr(OP_ADD, 4'd3, 4'd2, 4'd2);
        push_instr(OP_MUL, 4'd4, 4'd3, 4'd3);
        push_instr(OP_MUL, 4'd5, 4'd4, 4'd4);
        push_instr(OP_MUL, 4'd6, 4'd5, 4'd5);
        push_instr(OP_MUL, 4'd7, 4'd6, 4'd6);
        push_instr(OP_MUL, 4'd8, 4'd6, 4'd5);
        push_instr(OP_MUL, 4'd8, 4'd8, 4'd4);    // source equals destination
        push_instr(OP_MUL, 4'd8, 4'd8, 4'd3);
        push_instr(OP_MUL, 4'd9, 4'd7, 4'd8);    // most negative
        push_instr(OP_DIV, 4'd10, 4'd9, 4'd1);   // most negative over -1
        push_instr(OP_SUB, 4'd11, 4'd9, 4'd2);   // most positive
        push_instr(OP_ADD, 4'd12, 4'd11, 4'd2);
        push_instr(OP_DIV, 4'd13, 4'd11, 4'd3);
        push_instr(OP_DIV, 4'd14, 4'd1, 4'd3);
        push_instr(OP_MUL, 4'd15, 4'd11, 4'd11);
        drain();

        // random phases over several latency settings
        set_latencies(ADD_LAT_RST, MUL_LAT_RST, DIV_LAT_RST);
        push_random(70);
        drain();
        set_latencies(6'd0, 6'd0, 6'd0);
        push_random(70);
        drain();
        set_latencies(6'd63, 6'd63, 6'd63);
        push_random(60);
        drain();
        set_latencies(6'($urandom_range(1, 8)), 6'($urandom_range(1, 20)),
                      6'($urandom_range(1, 40)));
        push_random(50);
        drain();

        if (n_errors == 0 && wb_expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
